@@ rtl/core/ccb_pkg.sv @@
// Shared constants, register map and configuration type of the colour-key blitter.
package ccb_pkg;

  localparam int MAX_SIDE   = 2048;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int REG_W      = SIDE_W + 1;
  localparam int PIXEL_BITS = 16;
  localparam int PIX_W      = 16;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  typedef enum logic [2:0] {
    REG_MODE          = 3'd0,
    REG_DST_X         = 3'd1,
    REG_DST_Y         = 3'd2,
    REG_DST_WIDTH     = 3'd3,
    REG_DST_HEIGHT    = 3'd4,
    REG_SRC_WIDTH     = 3'd5,
    REG_COLOR_KEY     = 3'd6,
    REG_REPLACE_COLOR = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic                    mode;
    logic signed [REG_W-1:0] dst_x;
    logic signed [REG_W-1:0] dst_y;
    logic [REG_W-1:0]        dst_width;
    logic [REG_W-1:0]        dst_height;
    logic [REG_W-1:0]        src_width;
    logic [PIX_W-1:0]        color_key;
    logic [PIX_W-1:0]        replace_color;
  } ccb_cfg_t;

  // Clamp a side length to the largest supported image side.
  function automatic logic [REG_W-1:0] sat_side(input logic [REG_W-1:0] v);
    if (v > REG_W'(MAX_SIDE)) begin
      return REG_W'(MAX_SIDE);
    end
    return v;
  endfunction

  // Keep only the low PIXEL_BITS bits of a colour.
  function automatic logic [PIX_W-1:0] pix_mask(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] m;
    m = PIX_W'((1 << PIXEL_BITS) - 1);
    return v & m;
  endfunction

endpackage

@@ rtl/core/ccb_regs.sv @@
// APB configuration registers of the colour-key blitter.
module ccb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccb_pkg::ADDR_W-1:0] paddr,
  input  logic [ccb_pkg::DATA_W-1:0] pwdata,
  output logic [ccb_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ccb_pkg::ccb_cfg_t          cfg
);
  import ccb_pkg::*;

  reg_index_t index;
  logic       wr;

  assign index  = reg_index_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= 1'b0;
      cfg.dst_x         <= '0;
      cfg.dst_y         <= '0;
      cfg.dst_width     <= '0;
      cfg.dst_height    <= '0;
      cfg.src_width     <= REG_W'(1);
      cfg.color_key     <= '0;
      cfg.replace_color <= '0;
    end else if (wr) begin
      case (index)
        REG_MODE:          cfg.mode          <= pwdata[0];
        REG_DST_X:         cfg.dst_x         <= pwdata[REG_W-1:0];
        REG_DST_Y:         cfg.dst_y         <= pwdata[REG_W-1:0];
        REG_DST_WIDTH:     cfg.dst_width     <= pwdata[REG_W-1:0];
        REG_DST_HEIGHT:    cfg.dst_height    <= pwdata[REG_W-1:0];
        REG_SRC_WIDTH:     cfg.src_width     <= pwdata[REG_W-1:0];
        REG_COLOR_KEY:     cfg.color_key     <= pwdata[PIX_W-1:0];
        REG_REPLACE_COLOR: cfg.replace_color <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_MODE:          prdata = DATA_W'(cfg.mode);
      REG_DST_X:         prdata = DATA_W'(cfg.dst_x);
      REG_DST_Y:         prdata = DATA_W'(cfg.dst_y);
      REG_DST_WIDTH:     prdata = DATA_W'(cfg.dst_width);
      REG_DST_HEIGHT:    prdata = DATA_W'(cfg.dst_height);
      REG_SRC_WIDTH:     prdata = DATA_W'(cfg.src_width);
      REG_COLOR_KEY:     prdata = DATA_W'(cfg.color_key);
      REG_REPLACE_COLOR: prdata = DATA_W'(cfg.replace_color);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/clipped_colorkey_blitter_core.sv @@
// A result beat is registered in the cycle after its pixel beat is accepted.
// Throughput: one pixel per cycle; the result register drains while the next
// beat is taken, so only a stalled output holds off input.
// The clip compare, key compare and column/row counter step sit in one stage.
// Reset (synchronous, active high) clears the counters and the result valid,
// and loads register defaults: all zero except src_width, which is one.
module clipped_colorkey_blitter_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ccb_pkg::PIX_W-1:0]  src_pixel,
  input  logic                       last_pixel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       write_enable,
  output logic [ccb_pkg::SIDE_W-1:0] dst_col,
  output logic [ccb_pkg::SIDE_W-1:0] dst_row,
  output logic [ccb_pkg::PIX_W-1:0]  out_pixel,
  output logic                       blit_done,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccb_pkg::ADDR_W-1:0] paddr,
  input  logic [ccb_pkg::DATA_W-1:0] pwdata,
  output logic [ccb_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ccb_pkg::*;

  localparam int POS_W = REG_W + 2;

  ccb_cfg_t cfg;

  ccb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [SIDE_W-1:0] col_count;
  logic [SIDE_W-1:0] row_count;
  logic [SIDE_W-1:0] col_count_next;
  logic [SIDE_W-1:0] row_count_next;

  logic [REG_W-1:0]  sw;
  logic [REG_W-1:0]  dw;
  logic [REG_W-1:0]  dh;
  logic [POS_W-1:0]  x_pos;
  logic [POS_W-1:0]  y_pos;
  logic [PIX_W-1:0]  pix;
  logic [PIX_W-1:0]  key;
  logic              in_bounds;
  logic              opaque;
  logic              we;
  logic              in_acc;

  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    sw = sat_side(cfg.src_width);
    if (sw == '0) begin
      sw = REG_W'(1);
    end
    dw  = sat_side(cfg.dst_width);
    dh  = sat_side(cfg.dst_height);
    pix = pix_mask(src_pixel);
    key = pix_mask(cfg.color_key);

    // Sign-extend the origin and add the unsigned counter.
    x_pos = {{2{cfg.dst_x[REG_W-1]}}, cfg.dst_x} + POS_W'(col_count);
    y_pos = {{2{cfg.dst_y[REG_W-1]}}, cfg.dst_y} + POS_W'(row_count);
    in_bounds = !x_pos[POS_W-1] && (x_pos[POS_W-2:0] < {1'b0, dw}) &&
                !y_pos[POS_W-1] && (y_pos[POS_W-2:0] < {1'b0, dh});
    opaque = !((key != '0) && (pix == key));
    we     = in_bounds && opaque;

    // Advance the raster position; drop back to the origin after the last beat.
    if (last_pixel) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if ((REG_W'(col_count) + REG_W'(1)) >= sw) begin
      col_count_next = '0;
      if (REG_W'(row_count) + REG_W'(1) >= REG_W'(MAX_SIDE)) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_count + SIDE_W'(1);
      end
    end else begin
      col_count_next = col_count + SIDE_W'(1);
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      write_enable <= we;
      dst_col      <= we ? x_pos[SIDE_W-1:0] : '0;
      dst_row      <= we ? y_pos[SIDE_W-1:0] : '0;
      out_pixel    <= cfg.mode ? pix_mask(cfg.replace_color) : pix;
      blit_done    <= last_pixel;
    end
  end

  a_last_resets : assert property (@(posedge clk) disable iff (rst)
    in_acc && last_pixel |=> col_count == '0 && row_count == '0)
    else $error("counters not cleared after last beat");

  a_masked_pos : assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> dst_col == '0 && dst_row == '0)
    else $error("position not zero on disabled write");

  a_done_flag : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid && blit_done == $past(last_pixel))
    else $error("done flag does not follow last beat");

endmodule

@@ tb/clipped_colorkey_blitter_core_tb.sv @@
// Testbench for the clipped colour-key blitter core: directed and random pixel streams.
module clipped_colorkey_blitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic              we;
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
    logic [PIX_W-1:0]  pix;
    logic              done;
  } px_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [PIX_W-1:0]  src_pixel;
  logic              last_pixel;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              write_enable;
  logic [SIDE_W-1:0] dst_col;
  logic [SIDE_W-1:0] dst_row;
  logic [PIX_W-1:0]  out_pixel;
  logic              blit_done;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Blitter settings as the block should hold them.
  logic                    cfg_mode;
  logic signed [REG_W-1:0] cfg_dst_x;
  logic signed [REG_W-1:0] cfg_dst_y;
  logic [REG_W-1:0]        cfg_dst_w;
  logic [REG_W-1:0]        cfg_dst_h;
  logic [REG_W-1:0]        cfg_src_w;
  logic [PIX_W-1:0]        cfg_key;
  logic [PIX_W-1:0]        cfg_repl;

  // Position of the next source pixel within the sprite.
  int pred_col;
  int pred_row;

  px_result_t expected_px[$];

  int   send_idle_pct;
  int   recv_idle_pct;
  int   pixels_sent;
  int   results_seen;
  int   reg_writes;
  int   err_count;
  int   cycle_count;
  logic hold_active;
  event hold_off_go;

  clipped_colorkey_blitter_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .src_pixel    (src_pixel),
    .last_pixel   (last_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_enable (write_enable),
    .dst_col      (dst_col),
    .dst_row      (dst_row),
    .out_pixel    (out_pixel),
    .blit_done    (blit_done),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_px.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int side_limit(input logic [REG_W-1:0] v);
    if (v > REG_W'(MAX_SIDE)) begin
      return MAX_SIDE;
    end
    return int'(v);
  endfunction

  // Work out the result of one source pixel and step the sprite position.
  function automatic px_result_t predict_pixel(input logic [PIX_W-1:0] pix, input logic last);
    px_result_t r;
    int         sw;
    int         x;
    int         y;
    logic       on_dest;
    logic       opaque;
    sw = side_limit(cfg_src_w);
    if (sw < 1) begin
      sw = 1;
    end
    x = int'(cfg_dst_x) + pred_col;
    y = int'(cfg_dst_y) + pred_row;
    on_dest = (x >= 0) && (x < side_limit(cfg_dst_w)) && (y >= 0) && (y < side_limit(cfg_dst_h));
    opaque = !((cfg_key != '0) && (pix == cfg_key));
    r.we   = on_dest && opaque;
    r.col  = r.we ? SIDE_W'(x) : '0;
    r.row  = r.we ? SIDE_W'(y) : '0;
    r.pix  = cfg_mode ? cfg_repl : pix;
    r.done = last;
    if (last) begin
      pred_col = 0;
      pred_row = 0;
    end else if (pred_col + 1 >= sw) begin
      pred_col = 0;
      pred_row = (pred_row + 1 >= MAX_SIDE) ? 0 : pred_row + 1;
    end else begin
      pred_col = pred_col + 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (err_count < 40) begin
      $display("mismatch on %s at result %0d: got %0h, expected %0h", field, results_seen,
               got, want);
    end
    err_count++;
  endtask

  // Result side: check each beat against the oldest prediction, then pick next ready.
  always @(posedge clk) begin
    px_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        report_mismatch("unexpected result beat", int'(out_pixel), 0);
      end else begin
        want = expected_px.pop_front();
        if (write_enable !== want.we)
          report_mismatch("write_enable", int'(write_enable), int'(want.we));
        if (dst_col !== want.col) report_mismatch("dst_col", int'(dst_col), int'(want.col));
        if (dst_row !== want.row) report_mismatch("dst_row", int'(dst_row), int'(want.row));
        if (out_pixel !== want.pix)
          report_mismatch("out_pixel", int'(out_pixel), int'(want.pix));
        if (blit_done !== want.done)
          report_mismatch("blit_done", int'(blit_done), int'(want.done));
      end
      results_seen++;
    end
    if (hold_active) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_off_go);
      @(posedge clk);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    src_pixel  <= pix;
    last_pixel <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_px.push_back(predict_pixel(pix, last));
    pixels_sent++;
  endtask

  // Drop valid and wait until every result is out and the stage has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MODE:          cfg_mode  = value[0];
      REG_DST_X:         cfg_dst_x = value[REG_W-1:0];
      REG_DST_Y:         cfg_dst_y = value[REG_W-1:0];
      REG_DST_WIDTH:     cfg_dst_w = value[REG_W-1:0];
      REG_DST_HEIGHT:    cfg_dst_h = value[REG_W-1:0];
      REG_SRC_WIDTH:     cfg_src_w = value[REG_W-1:0];
      REG_COLOR_KEY:     cfg_key   = value[PIX_W-1:0];
      REG_REPLACE_COLOR: cfg_repl  = value[PIX_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_registers(input logic mode, input logic [REG_W-1:0] dx,
                               input logic [REG_W-1:0] dy, input logic [DATA_W-1:0] dw,
                               input logic [DATA_W-1:0] dh, input logic [DATA_W-1:0] sw,
                               input logic [PIX_W-1:0] key, input logic [PIX_W-1:0] repl);
    drain();
    write_register(REG_MODE, DATA_W'(mode));
    write_register(REG_DST_X, DATA_W'(dx));
    write_register(REG_DST_Y, DATA_W'(dy));
    write_register(REG_DST_WIDTH, dw);
    write_register(REG_DST_HEIGHT, dh);
    write_register(REG_SRC_WIDTH, sw);
    write_register(REG_COLOR_KEY, DATA_W'(key));
    write_register(REG_REPLACE_COLOR, DATA_W'(repl));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reset values: empty destination, so nothing may be written.
  task automatic test_reset_defaults();
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h5A5A, 1'b1);
  endtask

  task automatic test_clip_copy();
    int i;
    // Sprite hanging off the top-left corner.
    set_registers(1'b0, -12'sd1, -12'sd1, 4, 3, 3, 16'h0000, 16'h0000);
    for (i = 0; i < 9; i++) begin
      send_pixel(16'($urandom), i == 8);
    end
    // Sprite hanging off the right edge.
    set_registers(1'b0, 12'sd2, 12'sd1, 4, 3, 3, 16'h0000, 16'h0000);
    for (i = 0; i < 6; i++) begin
      send_pixel(16'($urandom), i == 5);
    end
  endtask

  task automatic test_color_key();
    set_registers(1'b0, 12'sd0, 12'sd0, 8, 8, 4, 16'hFFFF, 16'h0000);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h1234, 1'b1);
    // Key still blanks pixels when replacing.
    set_registers(1'b1, 12'sd0, 12'sd0, 8, 8, 4, 16'h0001, 16'hBEEF);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h0002, 1'b1);
  endtask

  // Image clear: a fill over the whole destination from the origin.
  task automatic test_fill_clear();
    int i;
    set_registers(1'b1, 12'sd0, 12'sd0, 3, 2, 3, 16'h0000, 16'hFFFF);
    for (i = 0; i < 6; i++) begin
      send_pixel(16'($urandom), i == 5);
    end
  endtask

  task automatic test_zero_src_width();
    set_registers(1'b0, 12'sd0, 12'sd0, 4, 4, 0, 16'h0000, 16'h0000);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h7FFE, 1'b0);
    send_pixel(16'hC3C3, 1'b1);
  endtask

  // Oversized sides saturate; positions at the far ends of the signed range.
  task automatic test_wide_registers();
    set_registers(1'b0, 12'h7FF, 12'sd0, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 16'h0000, 16'h0000);
    send_pixel(16'h0F0F, 1'b0);
    send_pixel(16'hF0F0, 1'b1);
    set_registers(1'b1, 12'h800, 12'h7FF, 12'hFFF, 12'hFFF, 12'h800, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h1111, 1'b0);
    send_pixel(16'h2222, 1'b1);
  endtask

  task automatic test_back_pressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_registers(1'b0, 12'sd0, 12'sd0, 16, 16, 5, 16'h0000, 16'h0000);
    -> hold_off_go;
    for (i = 0; i < 40; i++) begin
      send_pixel(16'($urandom), i == 39);
    end
  endtask

  task automatic test_random_blits(input int snd_pct, input int rcv_pct, input int n_items);
    int               sent;
    int               dw;
    int               dh;
    int               dx;
    int               dy;
    int               w_eff;
    int               len;
    int               i;
    logic [REG_W-1:0] sw;
    logic [PIX_W-1:0] key;
    logic [PIX_W-1:0] pix;
    logic             ends_blit;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      dw = ($urandom_range(7) == 0) ? int'($urandom_range(4095)) : int'($urandom_range(24));
      dh = ($urandom_range(7) == 0) ? int'($urandom_range(4095)) : int'($urandom_range(24));
      case ($urandom_range(11))
        0:       sw = '0;
        1:       sw = REG_W'($urandom);
        default: sw = REG_W'($urandom_range(1, 8));
      endcase
      if ($urandom_range(7) == 0) begin
        dx = int'($urandom_range(4095));
        dy = int'($urandom_range(4095));
      end else begin
        dx = int'($urandom_range(side_limit(REG_W'(dw)) + 12)) - 8;
        dy = int'($urandom_range(side_limit(REG_W'(dh)) + 12)) - 8;
      end
      key = ($urandom_range(2) == 0) ? '0 : PIX_W'($urandom);
      set_registers(1'($urandom), REG_W'(dx), REG_W'(dy), DATA_W'(dw), DATA_W'(dh),
                    DATA_W'(sw), key, PIX_W'($urandom));
      repeat (2) begin
        w_eff = side_limit(sw);
        if (w_eff < 1) begin
          w_eff = 1;
        end
        len = w_eff * int'($urandom_range(1, 6));
        if (len > 48) begin
          len = int'($urandom_range(1, 48));
        end
        // Now and then leave the blit open so the counters run on.
        ends_blit = ($urandom_range(9) != 0);
        for (i = 0; i < len; i++) begin
          pix = (key != '0 && $urandom_range(3) == 0) ? key : PIX_W'($urandom);
          send_pixel(pix, ends_blit && (i == len - 1));
        end
        sent += len;
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    src_pixel  = '0;
    last_pixel = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    cfg_mode   = 1'b0;
    cfg_dst_x  = '0;
    cfg_dst_y  = '0;
    cfg_dst_w  = '0;
    cfg_dst_h  = '0;
    cfg_src_w  = REG_W'(1);
    cfg_key    = '0;
    cfg_repl   = '0;
    pred_col   = 0;
    pred_row   = 0;
    pixels_sent  = 0;
    results_seen = 0;
    reg_writes   = 0;
    err_count    = 0;
    send_idle_pct = 8;
    recv_idle_pct = 63;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_clip_copy();
    test_color_key();
    test_fill_clear();
    test_zero_src_width();
    test_wide_registers();
    test_back_pressure();
    test_random_blits(8, 63, 100);
    test_random_blits(63, 8, 100);
    test_random_blits(0, 0, 100);
    drain();

    $display("covered %0d pixel beats, %0d result beats, %0d register writes", pixels_sent,
             results_seen, reg_writes);
    $display("clipping on all edges, keying, fill, saturated sides, open blits, long stall");
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
